### sv/hsr_pkg.sv
package hsr_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ScaledW  = DataW + FracBits;
  localparam int unsigned CountW   = 7;
  localparam int unsigned MaxIter  = 64;
  localparam int unsigned DivCntW  = $clog2(ScaledW + 1);

  localparam logic [CountW-1:0] CountCap = CountW'(MaxIter + 1);

  typedef enum logic [2:0] {
    SeqIdle,
    SeqDiv,
    SeqUpdate,
    SeqSquare,
    SeqCheck,
    SeqDone
  } hsr_state_e;

  typedef struct packed {
    logic [DataW-1:0]  root;
    logic [CountW-1:0] count;
    logic              hit;
  } hsr_result_t;

endpackage

### sv/hsr_div.sv
module hsr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hsr_pkg::ScaledW-1:0]  dividend_i,
  input  logic [hsr_pkg::DataW-1:0]    divisor_i,
  output logic                         done_o,
  output logic [hsr_pkg::ScaledW-1:0]  quotient_o
);
  import hsr_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW-1:0]   dsr_q, dsr_d;
  logic [ScaledW-1:0] quo_q, quo_d;

  logic [DataW:0]     rem_sh;
  logic [DataW+1:0]   diff;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[ScaledW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(ScaledW);
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (diff[DataW+1]) begin
        rem_d = rem_sh[DataW-1:0];
        quo_d = {quo_q[ScaledW-2:0], 1'b0};
      end else begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[ScaledW-2:0], 1'b1};
      end
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### sv/hsr_seq.sv
module hsr_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hsr_pkg::DataW-1:0]  radicand_i,
  input  logic [hsr_pkg::DataW-1:0]  tolerance_i,
  output logic                       idle_o,
  output logic                       res_valid_o,
  input  logic                       res_take_i,
  output hsr_pkg::hsr_result_t       res_o
);
  import hsr_pkg::*;

  hsr_state_e state_q, state_d;

  logic [DataW-1:0]     x_q;
  logic [DataW-1:0]     tol_q;
  logic [DataW-1:0]     y_q;
  logic [CountW-1:0]    count_q;
  logic                 hit_q;
  logic [2*DataW-1:0]   prod_q;

  logic                 div_start;
  logic                 div_done;
  logic [ScaledW-1:0]   div_quo;
  logic [DataW-1:0]     div_x;
  logic [DataW-1:0]     div_y;
  logic [DataW-1:0]     div_y_safe;

  logic [ScaledW:0]     sum;
  logic [ScaledW-1:0]   half;
  logic [DataW-1:0]     y_next;
  logic [DataW-1:0]     diff_d;
  logic                 near_enough;
  logic                 sq_ok;
  logic                 at_cap;

  assign sum    = {{(FracBits+1){1'b0}}, y_q} + {1'b0, div_quo};
  assign half   = sum[ScaledW:1];
  assign y_next = (|half[ScaledW-1:DataW]) ? '1 : half[DataW-1:0];

  assign near_enough = (y_q <= tol_q);
  assign diff_d      = y_q - tol_q;
  assign sq_ok       = (prod_q <= {{(DataW-FracBits){1'b0}}, x_q, {FracBits{1'b0}}});
  assign at_cap      = (count_q == CountCap);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SeqIdle: begin
        if (start_i) begin
          state_d = (radicand_i == '0) ? SeqDone : SeqDiv;
        end
      end
      SeqDiv: begin
        if (div_done) begin
          state_d = SeqUpdate;
        end
      end
      SeqUpdate: state_d = SeqSquare;
      SeqSquare: state_d = near_enough ? SeqDone : SeqCheck;
      SeqCheck:  state_d = (sq_ok || at_cap) ? SeqDone : SeqDiv;
      SeqDone: begin
        if (res_take_i) begin
          state_d = SeqIdle;
        end
      end
      default: state_d = SeqIdle;
    endcase
  end

  // outputs
  always_comb begin
    div_start   = 1'b0;
    div_x       = x_q;
    div_y       = y_q;
    idle_o      = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      SeqIdle: begin
        idle_o    = 1'b1;
        div_x     = radicand_i;
        div_y     = radicand_i;
        div_start = start_i && (radicand_i != '0);
      end
      SeqCheck: div_start = !(sq_ok || at_cap);
      SeqDone:  res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // zero iterate cannot occur, keep the divisor nonzero anyway
  assign div_y_safe = (div_y == '0) ? DataW'(1) : div_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SeqIdle: begin
        x_q     <= radicand_i;
        tol_q   <= tolerance_i;
        y_q     <= radicand_i;
        count_q <= CountW'(1);
        hit_q   <= 1'b0;
      end
      SeqUpdate: begin
        y_q     <= y_next;
        count_q <= count_q + CountW'(1);
      end
      SeqSquare: prod_q <= (2*DataW)'(diff_d) * (2*DataW)'(diff_d);
      SeqCheck:  hit_q  <= !sq_ok && at_cap;
      default: ;
    endcase
  end

  hsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({div_x, {FracBits{1'b0}}}),
    .divisor_i  (div_y_safe),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign res_o.root  = y_q;
  assign res_o.count = count_q;
  assign res_o.hit   = hit_q;

endmodule

### sv/heron_square_root.sv
// a zero radicand skips the division; otherwise n heron steps run (n <= 64)
// each step is a bit-serial division, its registered done, then update, squaring and compare
// a last step that ends on y <= tol skips the compare state
// one transaction in flight; the next is taken once the previous result leaves the sequencer
// the output register holds a result while the next transaction is already running
// reset is asynchronous, active low, and clears the sequencer and the output valid
module heron_square_root (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hsr_pkg::DataW-1:0]    radicand_i,
  input  logic [hsr_pkg::DataW-1:0]    tolerance_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hsr_pkg::DataW-1:0]    root_o,
  output logic [hsr_pkg::CountW-1:0]   element_count_o,
  output logic                         hit_limit_o
);
  import hsr_pkg::*;

  logic        idle;
  logic        res_valid;
  logic        res_take;
  hsr_result_t res;
  hsr_result_t out_q;
  logic        out_valid_q, out_valid_d;

  assign in_stall_o = !idle;

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  hsr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && idle),
    .radicand_i  (radicand_i),
    .tolerance_i (tolerance_i),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  assign out_valid_o     = out_valid_q;
  assign root_o          = out_q.root;
  assign element_count_o = out_q.count;
  assign hit_limit_o     = out_q.hit;

endmodule

### sim/hsr_checker.sv
`timescale 1ns / 1ps

module hsr_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [hsr_pkg::DataW-1:0]  radicand_i,
  input  logic [hsr_pkg::DataW-1:0]  tolerance_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [hsr_pkg::DataW-1:0]  root_i,
  input  logic [hsr_pkg::CountW-1:0] element_count_i,
  input  logic                       hit_limit_i,
  output int unsigned                mismatch_count_o,
  output int unsigned                pending_count_o
);
  import hsr_pkg::*;

  hsr_result_t expected_roots_q[$];
  int unsigned mismatch_total = 0;
  int unsigned pending_total  = 0;

  // heron steps from y0 = x, stopping once the iterate is within tolerance above the root
  function automatic hsr_result_t heron_root(input logic [DataW-1:0] x,
                                             input logic [DataW-1:0] tol);
    logic [63:0] scaled;
    logic [63:0] y;
    logic [63:0] quotient;
    logic [63:0] next_y;
    logic [63:0] diff;
    logic [63:0] tol_wide;
    int unsigned elements;
    bit          met;
    hsr_result_t res;
    scaled   = {32'b0, x} << FracBits;
    tol_wide = {32'b0, tol};
    y        = {32'b0, x};
    elements = 1;
    met      = (x == '0);
    for (int k = 0; k < MaxIter && !met; k++) begin
      if (y == 0) begin
        y = 1;
      end
      quotient = scaled / y;
      next_y   = (y + quotient) >> 1;
      if (next_y > 64'hFFFF_FFFF) begin
        next_y = 64'hFFFF_FFFF;
      end
      y = next_y;
      elements++;
      if (y <= tol_wide) begin
        met = 1'b1;
      end else begin
        diff = y - tol_wide;
        met  = (diff * diff <= scaled);
      end
    end
    res.root  = y[DataW-1:0];
    res.count = CountW'(elements);
    res.hit   = !met;
    return res;
  endfunction

  assign mismatch_count_o = mismatch_total;
  assign pending_count_o  = pending_total;

  always @(posedge clk_i) begin
    hsr_result_t exp_res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        expected_roots_q.insert(expected_roots_q.size(),
                                heron_root(radicand_i, tolerance_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_roots_q.size() == 0) begin
          $error("result with no transaction pending: root %h count %0d hit %0b",
                 root_i, element_count_i, hit_limit_i);
          mismatch_total++;
        end else begin
          exp_res = expected_roots_q.pop_front();
          if (root_i !== exp_res.root) begin
            $error("root: expected %h, actual %h", exp_res.root, root_i);
            mismatch_total++;
          end
          if (element_count_i !== exp_res.count) begin
            $error("element_count: expected %0d, actual %0d", exp_res.count,
                   element_count_i);
            mismatch_total++;
          end
          if (hit_limit_i !== exp_res.hit) begin
            $error("hit_limit: expected %0b, actual %0b", exp_res.hit, hit_limit_i);
            mismatch_total++;
          end
        end
      end
      pending_total = expected_roots_q.size();
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hsr_pkg::*;

  localparam int unsigned RandomItems   = 600;
  localparam int unsigned HoldOffItem   = 100;
  localparam int unsigned HoldOffCycles = 4000;
  localparam int unsigned DrainCycles   = 3400;
  localparam int unsigned WatchdogLimit = 12000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DataW-1:0]  radicand = '0;
  logic [DataW-1:0]  tolerance = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DataW-1:0]  root;
  logic [CountW-1:0] element_count;
  logic              hit_limit;
  int unsigned       mismatch_count;
  int unsigned       pending_count;
  int unsigned       quiet_cycles = 0;
  bit                hold_request = 1'b0;
  bit                sender_burst = 1'b0;
  bit                receiver_burst = 1'b0;

  always #2 clk_i = ~clk_i;

  heron_square_root dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .radicand_i      (radicand),
    .tolerance_i     (tolerance),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .root_o          (root),
    .element_count_o (element_count),
    .hit_limit_o     (hit_limit)
  );

  hsr_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .radicand_i       (radicand),
    .tolerance_i      (tolerance),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .root_i           (root),
    .element_count_i  (element_count),
    .hit_limit_i      (hit_limit),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input logic [DataW-1:0] x, input logic [DataW-1:0] tol);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 31) == 0) begin
      sender_burst = !sender_burst;
    end
    if (gap != 0) begin
      in_valid  = 1'b0;
      radicand  = $urandom;
      tolerance = $urandom;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  = 1'b1;
    radicand  = x;
    tolerance = tol;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_radicand();
    logic [DataW-1:0] k;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 255);
      2: begin
        // exact squares in the scaled domain
        k = $urandom_range(0, 65535);
        return k * k;
      end
      3: return 32'h1 << $urandom_range(0, 31);
      4: return $urandom_range(0, 32'h0010_0000);
      default: return ~DataW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_tolerance();
    logic [DataW-1:0] t;
    case ($urandom_range(0, 4))
      0: t = 1;
      1: t = $urandom_range(1, 255);
      2: t = $urandom_range(1, 32'h0001_0000);
      3: t = $urandom;
      default: t = ~DataW'($urandom_range(0, 255));
    endcase
    return (t == '0) ? 1 : t;
  endfunction

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, zero radicand, exact squares, zero tolerance
    offer(32'h0000_0000, 32'h0000_0001);
    offer(32'h0000_0000, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 32'h0000_0001);
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 32'h0001_0000);
    offer(32'h0000_0001, 32'h0000_0001);
    offer(32'h0000_0001, 32'hFFFF_FFFF);
    offer(32'h0001_0000, 32'h0000_0001);
    offer(32'h0004_0000, 32'h0000_0001);
    offer(32'h0002_0000, 32'h0000_0010);
    offer(32'h8000_0000, 32'h0000_0001);
    offer(32'h0000_FFFF, 32'h0000_8000);
    offer(32'hAAAA_AAAA, 32'h5555_5555);
    offer(32'h5555_5555, 32'hAAAA_AAAA);
    offer(32'h7FFF_FFFF, 32'h8000_0000);
    offer(32'h0004_0000, 32'h0000_0000);
    offer(32'h0002_0000, 32'h0000_0000);
    offer(32'hFFFF_FFFF, 32'h0000_0000);
    offer(32'h0000_0000, 32'h0000_0000);

    for (int i = 0; i < RandomItems; i++) begin
      if (i == HoldOffItem) begin
        hold_request = 1'b1;
      end
      offer(pick_radicand(), pick_tolerance());
    end
    in_valid = 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side: random stall per result, plus one long hold-off so the input backs up
  initial begin
    int unsigned pause;
    @(negedge clk_i);
    while (!rst_ni) @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall    = 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      pause = receiver_burst ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 31) == 0) begin
        receiver_burst = !receiver_burst;
      end
      if (pause != 0) begin
        out_stall = 1'b1;
        repeat (pause) @(negedge clk_i);
      end
      out_stall = 1'b0;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

### sim.f
sv/hsr_pkg.sv
sv/hsr_div.sv
sv/hsr_seq.sv
sv/heron_square_root.sv
sim/hsr_checker.sv
sim/testbench.sv
